[rtl/core/unrd_pkg.sv]
// ----------------------------------------------------------------------------
// unrd_pkg
// Shared types and constants for the unsigned non-restoring divider.
// ----------------------------------------------------------------------------
package unrd_pkg;

  // Width of every data word on the ports.
  localparam int DATA_W = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture operands and clear the partial remainder
    logic step;   // one add/subtract iteration, one quotient bit
    logic fix;    // final correction of a negative remainder
  } unrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dz;     // captured divisor is zero
  } unrd_stat_t;

endpackage
// ----------------------------------------------------------------------------

[rtl/core/unrd_dpath.sv]
// ----------------------------------------------------------------------------
// unrd_dpath
// Operand registers, partial remainder, add/subtract unit and correction adder of the divider.
// ----------------------------------------------------------------------------
module unrd_dpath #(
  parameter int WIDTH = 64
) (
  input  logic                       clk,
  input  logic [unrd_pkg::DATA_W-1:0] dividend,
  input  logic [unrd_pkg::DATA_W-1:0] divisor,
  input  unrd_pkg::unrd_cmd_t        cmd,
  output unrd_pkg::unrd_stat_t       stat,
  output logic [unrd_pkg::DATA_W-1:0] quotient,
  output logic [unrd_pkg::DATA_W-1:0] remainder,
  output logic                       divide_by_zero
);
  import unrd_pkg::*;

  // Partial remainder is kept signed, one bit wider than the operands.
  logic [WIDTH:0]   prem;
  logic [WIDTH:0]   prem_next;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvsr;
  logic             dz;

  logic [WIDTH+1:0] shifted;
  logic [WIDTH+1:0] dvsr_ext;
  logic [WIDTH+1:0] sum;
  logic [WIDTH:0]   fixed;

  always_comb begin
    shifted  = {prem, quo[WIDTH-1]};
    dvsr_ext = {2'b00, dvsr};
    if (prem[WIDTH]) begin
      sum = shifted + dvsr_ext;
    end else begin
      sum = shifted - dvsr_ext;
    end
    fixed = prem + {1'b0, dvsr};
    prem_next = sum[WIDTH:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prem <= '0;
      quo  <= dividend[WIDTH-1:0];
      dvsr <= divisor[WIDTH-1:0];
      dz   <= (divisor[WIDTH-1:0] == '0);
    end else if (cmd.step) begin
      prem <= prem_next;
      quo  <= {quo[WIDTH-2:0], ~prem_next[WIDTH]};
    end else if (cmd.fix && prem[WIDTH]) begin
      prem <= fixed;
    end
  end

  assign stat.dz = dz;

  // With a zero divisor no step runs, so the quotient register still holds
  // the masked dividend, which becomes the remainder.
  assign quotient       = dz ? '0 : DATA_W'(quo);
  assign remainder      = dz ? DATA_W'(quo) : DATA_W'(prem[WIDTH-1:0]);
  assign divide_by_zero = dz;

endmodule
// ----------------------------------------------------------------------------

[rtl/core/unrd_ctrl.sv]
// ----------------------------------------------------------------------------
// unrd_ctrl
// Sequencer of the divider: load, iterate, correct, deliver; a zero divisor skips iterate and correct.
// ----------------------------------------------------------------------------
module unrd_ctrl #(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  unrd_pkg::unrd_stat_t stat,
  output unrd_pkg::unrd_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import unrd_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             last;

  assign busy   = (state == ST_RUN) || (state == ST_FIX);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;
  assign last   = (count == CNT_W'(WIDTH - 1));

  always_comb begin
    cmd.load   = accept;
    cmd.step   = (state == ST_RUN) && !stat.dz;
    cmd.fix    = (state == ST_FIX);
    state_next = state;
    unique case (state)
      ST_IDLE, ST_DONE: begin
        state_next = accept ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (stat.dz) begin
          state_next = ST_DONE;
        end else if (last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
      end else if (cmd.step) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule
// ----------------------------------------------------------------------------

[rtl/core/unsigned_nonrestoring_divider.sv]
// ----------------------------------------------------------------------------
// unsigned_nonrestoring_divider
// Unsigned WIDTH-bit divider giving quotient and remainder by non-restoring
// division, with a flag for a zero divisor.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Word
//   --------  -----------------  -----------------------------------------
//   input     start / busy       dividend, divisor
//   result    done (one cycle)   quotient, remainder, divide_by_zero
//
// A word is taken at a clock edge where start is high and busy is low. The
// sequencer then iterates in the shared add/subtract unit, one quotient bit
// per cycle, applies the final remainder correction and shows the result;
// busy stays high until the result is shown. A zero divisor skips the
// iterations and the correction. The result is shown for exactly one cycle
// with done high; the receiver cannot hold it off, and busy is already low
// in that cycle so the next word may be taken at the same edge. Reset is
// synchronous and returns the sequencer to idle; no result is pending
// after.
// Input bits at or above WIDTH are ignored and results are zero-extended.
// ----------------------------------------------------------------------------
module unsigned_nonrestoring_divider #(
  parameter int WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [unrd_pkg::DATA_W-1:0] dividend,
  input  logic [unrd_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [unrd_pkg::DATA_W-1:0] quotient,
  output logic [unrd_pkg::DATA_W-1:0] remainder,
  output logic                       divide_by_zero
);
  import unrd_pkg::*;

  unrd_cmd_t  cmd;
  unrd_stat_t stat;

  // The controller owns the handshake and the iteration count.
  unrd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the operands and the partial remainder; its result
  // registers stay stable through the done cycle.
  unrd_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk            (clk),
    .dividend       (dividend),
    .divisor        (divisor),
    .cmd            (cmd),
    .stat           (stat),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

endmodule
// ----------------------------------------------------------------------------

[rtl/core/unrd_checker.sv]
// ----------------------------------------------------------------------------
// unrd_checker
// Port-level checks of the divider's handshake and result timing.
// ----------------------------------------------------------------------------
module unrd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [unrd_pkg::DATA_W-1:0] quotient,
  input logic                       divide_by_zero
);
  import unrd_pkg::*;

  // A taken word always makes the divider busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("divider not busy after a word was taken");

  // Busy only rises because a word was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // The result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // A zero divisor always reports a zero quotient.
  a_dz_quot: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '0))
    else $error("nonzero quotient with divide_by_zero");

endmodule

bind unsigned_nonrestoring_divider unrd_checker u_unrd_checker (.*);
// ----------------------------------------------------------------------------
